// File: src/ctif_pkg.sv
// Package for the coprime triple index filter.
// Holds the operand widths and derived counter widths; no dependencies.
`default_nettype none
package ctif_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [SHIFT_WIDTH-1:0] shift_t;

endpackage
`default_nettype wire

// File: src/ctif_in_if.sv
// Input channel of the coprime triple index filter: valid/ready plus one item.
// Depends on ctif_pkg for the field types.
`default_nettype none
interface ctif_in_if;
  logic               valid;
  logic               ready;
  ctif_pkg::value_t   a_value;
  ctif_pkg::value_t   b_value;
  ctif_pkg::index_t   pair_index;

  modport source (output valid, output a_value, output b_value, output pair_index,
                  input ready);
  modport sink (input valid, input a_value, input b_value, input pair_index,
                output ready);
endinterface
`default_nettype wire

// File: src/ctif_out_if.sv
// Result channel of the coprime triple index filter: valid/ready plus kept index.
// Depends on ctif_pkg for the field type.
`default_nettype none
interface ctif_out_if;
  logic             valid;
  logic             ready;
  ctif_pkg::index_t kept_index;

  modport source (output valid, output kept_index, input ready);
  modport sink (input valid, input kept_index, output ready);
endinterface
`default_nettype wire

// File: src/coprime_triple_index_filter.sv
// Coprime triple index filter: emits the pair index when gcd(a, b, index) is 1.
// Depends on ctif_pkg, ctif_in_if and ctif_out_if.
//
// Usage:
//   in_ch carries one item (a_value, b_value, pair_index) per valid/ready
//   handshake. in_ch.ready is high only while the sequencer is idle; one
//   item is worked on at a time.
//   out_ch carries kept_index when the three-way gcd equals 1; items whose
//   gcd is not 1 produce no result.
//   The gcd runs as two binary-gcd passes, gcd(a, b) then gcd(that, index),
//   on one shared compare/subtract/shift unit, one step per cycle. The number
//   of steps in each pass, and so the time until a result is loaded, is set
//   by the operand bit patterns. Input is accepted again the cycle after the
//   result is loaded into the output register or the item is dropped, so one
//   item is finished before the next is taken.
//   The result sits in an output register; if out_ch.ready is low when a
//   new result is ready, the sequencer holds it until the register frees up.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result.
`default_nettype none
module coprime_triple_index_filter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ctif_in_if.sink    in_ch,
  ctif_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN1 = 2'd1;
  localparam logic [1:0] ST_RUN2 = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  ctif_pkg::value_t  u_r, u_nxt;
  ctif_pkg::value_t  v_r, v_nxt;
  ctif_pkg::shift_t  k_r, k_nxt;
  ctif_pkg::index_t  idx_r, idx_nxt;
  logic              keep_r, keep_nxt;
  logic              out_valid_r, out_valid_nxt;
  ctif_pkg::index_t  out_idx_r, out_idx_nxt;

  logic              in_fire;
  logic              any_zero;
  logic              u_ge_v;
  ctif_pkg::value_t  sub_a, sub_b, diff;
  ctif_pkg::value_t  u_step, v_step;
  ctif_pkg::shift_t  k_step;
  ctif_pkg::value_t  merged;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept_index = out_idx_r;

  // Shared step unit: one binary-gcd step per cycle.
  assign any_zero = (u_r == '0) || (v_r == '0);
  assign u_ge_v   = (u_r >= v_r);
  assign sub_a    = u_ge_v ? u_r : v_r;
  assign sub_b    = u_ge_v ? v_r : u_r;
  assign diff     = sub_a - sub_b;
  assign merged   = u_r | v_r;

  always_comb begin
    u_step = u_r;
    v_step = v_r;
    k_step = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_step = u_r >> 1;
      v_step = v_r >> 1;
      k_step = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_step = u_r >> 1;
    end else if (!v_r[0]) begin
      v_step = v_r >> 1;
    end else if (u_ge_v) begin
      u_step = diff >> 1;
    end else begin
      v_step = diff >> 1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          u_nxt     = in_ch.a_value;
          v_nxt     = in_ch.b_value;
          k_nxt     = '0;
          idx_nxt   = in_ch.pair_index;
          state_nxt = ST_RUN1;
        end
      end
      ST_RUN1: begin
        if (any_zero) begin
          u_nxt     = merged << k_r;
          v_nxt     = ctif_pkg::value_t'(idx_r);
          k_nxt     = '0;
          state_nxt = ST_RUN2;
        end else begin
          u_nxt = u_step;
          v_nxt = v_step;
          k_nxt = k_step;
        end
      end
      ST_RUN2: begin
        if (any_zero) begin
          keep_nxt  = (k_r == '0) && (merged == ctif_pkg::value_t'(1));
          state_nxt = ST_FIN;
        end else begin
          u_nxt = u_step;
          v_nxt = v_step;
          k_nxt = k_step;
        end
      end
      ST_FIN: begin
        if (!keep_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      keep_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      keep_r      <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    k_r       <= k_nxt;
    idx_r     <= idx_nxt;
    out_idx_r <= out_idx_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN1))
    else $error("accepted item did not start the first gcd pass");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN) && $past(keep_r))
    else $error("result raised outside the finish step");

  a_kept_index_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_idx_r == $past(idx_r)))
    else $error("kept index differs from the item index");

  a_keep_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && keep_r) |-> (k_r == '0))
    else $error("kept item has an even common factor");

endmodule
`default_nettype wire
